// File: hdl/sfr_pkg.sv
package sfr_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  // Byte positions and frame indexes are compared in nine bits so that a
  // store of 256 bytes still fits.
  localparam int IDX_W = 9;
  localparam logic [IDX_W-1:0] BUF_LIM = IDX_W'(BUFFER_BYTES);

  localparam logic [7:0] HDR_FIRST = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;
  localparam logic [7:0] MIN_LENGTH = 8'd4;
  localparam logic [4:0] MAX_WORDS = 5'd30;
  localparam logic [4:0] WORDS_RESET = 5'd19;
  localparam logic [IDX_W-1:0] FIRST_WORD_BYTE = IDX_W'(4);

  typedef enum logic [1:0] {
    KIND_WORD    = 2'd0,
    KIND_SUM_ERR = 2'd1,
    KIND_LEN_ERR = 2'd2
  } sfr_kind_t;

  // Event from the byte parser to the word emitter.
  typedef struct packed {
    logic       err;
    sfr_kind_t  kind;
    logic [7:0] ftype;
    logic       start;
    logic [4:0] nwords;
  } sfr_evt_t;

  // Status from the word emitter back to the byte parser.
  typedef struct packed {
    logic busy;
    logic can_load;
  } sfr_stat_t;

endpackage

// File: hdl/sfr_byte_if.sv
interface sfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hdl/sfr_result_if.sv
interface sfr_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         frame_type;
  logic [4:0]         word_index;
  logic signed [15:0] word_value;
  logic               last;

  modport source (output valid, output kind, output frame_type, output word_index,
                  output word_value, output last, input ready);
  modport sink (input valid, input kind, input frame_type, input word_index,
                input word_value, input last, output ready);
endinterface

// File: hdl/sfr_ram.sv
module sfr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/sfr_parser.sv
module sfr_parser
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  input  sfr_stat_t         stat,
  output sfr_evt_t          evt,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [7:0]        mem_wdata
);

  typedef enum logic [1:0] {
    P_HDR1,
    P_HDR2,
    P_LEN,
    P_BODY
  } phase_t;

  phase_t     phase_r;
  logic [7:0] len_r;
  logic [7:0] pos_r;
  logic [7:0] sum_r;
  logic [7:0] type_r;
  logic [4:0] wte_r;

  logic       accept;
  logic       body_more;
  logic       len_bad;
  logic       may_result;
  logic       put;
  logic [7:0] wpos;
  logic [7:0] sum_base;
  logic [4:0] nwords;

  always_comb begin
    body_more = ({1'b0, pos_r} + IDX_W'(1)) < {1'b0, len_r};
    len_bad = (rx_byte < MIN_LENGTH) || ({1'b0, rx_byte} > BUF_LIM);
    // Only a length byte or the checksum byte can produce a result, so any
    // other byte is taken even with the output register full, unless busy.
    may_result = (phase_r == P_LEN) || ((phase_r == P_BODY) && !body_more);
    in_ready = !stat.busy && (stat.can_load || !may_result);
    accept = in_valid && in_ready;

    if (wte_r == 5'd0) begin
      nwords = 5'd1;
    end else if (wte_r > MAX_WORDS) begin
      nwords = MAX_WORDS;
    end else begin
      nwords = wte_r;
    end

    wpos = (phase_r == P_HDR1) ? 8'd0 : pos_r;
    sum_base = (phase_r == P_HDR1) ? 8'd0 : sum_r;

    put = 1'b0;
    evt = '0;
    evt.nwords = nwords;
    unique case (phase_r)
      P_HDR1: put = (rx_byte == HDR_FIRST);
      P_HDR2: put = (rx_byte == HDR_SECOND);
      P_LEN: begin
        put = !len_bad;
        if (len_bad) begin
          evt.err = accept;
          evt.kind = KIND_LEN_ERR;
        end
      end
      P_BODY: begin
        put = 1'b1;
        evt.ftype = (pos_r == 8'd3) ? rx_byte : type_r;
        if (!body_more) begin
          if (rx_byte != sum_r) begin
            evt.err = accept;
            evt.kind = KIND_SUM_ERR;
          end else begin
            evt.start = accept;
          end
        end
      end
      default: put = 1'b0;
    endcase

    mem_we = accept && put && ({1'b0, wpos} < BUF_LIM);
    mem_waddr = wpos[ADDR_W-1:0];
    mem_wdata = rx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_HDR1;
      len_r <= 8'd0;
      pos_r <= 8'd0;
      sum_r <= 8'd0;
      wte_r <= WORDS_RESET;
    end else begin
      if (cfg_we) begin
        wte_r <= cfg_wdata;
      end
      if (accept) begin
        if (put) begin
          sum_r <= sum_base + rx_byte;
          pos_r <= wpos + 8'd1;
        end
        unique case (phase_r)
          P_HDR1: phase_r <= put ? P_HDR2 : P_HDR1;
          P_HDR2: phase_r <= put ? P_LEN : P_HDR1;
          P_LEN: begin
            len_r <= rx_byte;
            phase_r <= put ? P_BODY : P_HDR1;
          end
          P_BODY: phase_r <= body_more ? P_BODY : P_HDR1;
          default: phase_r <= P_HDR1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && put && (wpos == 8'd3)) begin
      type_r <= rx_byte;
    end
  end

endmodule

// File: hdl/sfr_emitter.sv
module sfr_emitter
  import sfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sfr_evt_t           evt,
  output sfr_stat_t          stat,
  output logic               mem_re,
  output logic [ADDR_W-1:0]  mem_raddr,
  input  logic [7:0]         mem_rdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_frame_type,
  output logic [4:0]         out_word_index,
  output logic signed [15:0] out_word_value,
  output logic               out_last
);

  typedef enum logic [1:0] {
    E_IDLE,
    E_HI,
    E_LO,
    E_WAIT
  } estate_t;

  estate_t            st_r;
  logic [4:0]         idx_r;
  logic [4:0]         n_r;
  logic [7:0]         type_r;
  logic [7:0]         hi_r;
  logic               hi_ok_r;
  logic               lo_ok_r;
  logic               out_valid_r;
  logic [1:0]         kind_r;
  logic [7:0]         ftype_r;
  logic [4:0]         widx_r;
  logic signed [15:0] wval_r;
  logic               last_r;

  logic [IDX_W-1:0]   hi_idx;
  logic [IDX_W-1:0]   lo_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               can_load;
  logic               load;
  logic               is_last;
  logic [7:0]         lo_byte;

  always_comb begin
    hi_idx = FIRST_WORD_BYTE + IDX_W'({idx_r, 1'b0});
    lo_idx = hi_idx + IDX_W'(1);
    rd_idx = (st_r == E_LO) ? lo_idx : hi_idx;
    mem_re = (st_r == E_HI) || (st_r == E_LO);
    mem_raddr = rd_idx[ADDR_W-1:0];
    can_load = !out_valid_r || out_ready;
    load = ((st_r == E_IDLE) && evt.err) || ((st_r == E_WAIT) && can_load);
    is_last = ({1'b0, idx_r} + 6'd1) == {1'b0, n_r};
    // Bytes beyond the end of the store read as zero.
    lo_byte = lo_ok_r ? mem_rdata : 8'd0;
    stat.busy = (st_r != E_IDLE);
    stat.can_load = can_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
      out_valid_r <= 1'b0;
      idx_r <= 5'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        E_IDLE: begin
          if (evt.err) begin
            kind_r <= evt.kind;
            ftype_r <= evt.ftype;
            widx_r <= 5'd0;
            wval_r <= 16'sd0;
            last_r <= 1'b1;
          end else if (evt.start) begin
            st_r <= E_HI;
            idx_r <= 5'd0;
            n_r <= evt.nwords;
            type_r <= evt.ftype;
          end
        end
        E_HI: begin
          hi_ok_r <= hi_idx < BUF_LIM;
          st_r <= E_LO;
        end
        E_LO: begin
          lo_ok_r <= lo_idx < BUF_LIM;
          hi_r <= hi_ok_r ? mem_rdata : 8'd0;
          st_r <= E_WAIT;
        end
        E_WAIT: begin
          if (can_load) begin
            kind_r <= KIND_WORD;
            ftype_r <= type_r;
            widx_r <= idx_r;
            wval_r <= signed'({hi_r, lo_byte});
            last_r <= is_last;
            idx_r <= idx_r + 5'd1;
            st_r <= is_last ? E_IDLE : E_HI;
          end
        end
        default: st_r <= E_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = kind_r;
  assign out_frame_type = ftype_r;
  assign out_word_index = widx_r;
  assign out_word_value = wval_r;
  assign out_last = last_r;

endmodule

// File: hdl/sensor_frame_receiver_top.sv
// Channel   Direction  Payload
// in_ch     sink       rx_byte[7:0]
// out_ch    source     kind[1:0], frame_type[7:0], word_index[4:0], word_value[15:0], last
// cfg       write      cfg_wdata[4:0] = words_to_emit
//
// Received frame bytes go into a 64-entry store. After a frame with a good checksum,
// each payload word takes two reads of the single store read port and one output
// load, and the input is held off until the last word is loaded. Error results
// are loaded at once. Reset is synchronous, active low, and clears the control
// state only; the store needs no clearing pass. A stalled output holds its word,
// and the next input byte is still taken unless a word burst is under way or
// the byte could produce a result of its own.
module sensor_frame_receiver_top
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sfr_byte_if.sink   in_ch,
  sfr_result_if.source out_ch,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  sfr_evt_t          evt;
  sfr_stat_t         stat;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  sfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .rx_byte   (in_ch.rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .evt       (evt),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  sfr_ram #(
    .DEPTH (BUFFER_BYTES),
    .WIDTH (8)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sfr_emitter u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .evt            (evt),
    .stat           (stat),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.kind),
    .out_frame_type (out_ch.frame_type),
    .out_word_index (out_ch.word_index),
    .out_word_value (out_ch.word_value),
    .out_last       (out_ch.last)
  );

endmodule

// File: hdl/sfr_checker.sv
module sfr_checker
  import sfr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic [7:0]         frame_type,
  input logic [4:0]         word_index,
  input logic signed [15:0] word_value,
  input logic               last
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(frame_type)
      && $stable(word_index) && $stable(word_value) && $stable(last))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (kind == KIND_WORD) || (kind == KIND_SUM_ERR) || (kind == KIND_LEN_ERR))
    else $error("unknown result kind");

  // An error result is the only result of its frame.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind != KIND_WORD) |-> last && (word_index == 5'd0) && (word_value == 16'sd0))
    else $error("error result malformed");

  // While a frame still has words to send, no input word is taken.
  a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == KIND_WORD) && !last |-> !in_ready)
    else $error("input taken during word burst");

  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_valid && (kind == KIND_WORD) && $rose(out_valid)
      |-> word_index == 5'd0 || !$past(in_valid && in_ready))
    else $error("word burst did not start at index zero");

endmodule

bind sensor_frame_receiver_top sfr_checker u_sfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .kind       (out_ch.kind),
  .frame_type (out_ch.frame_type),
  .word_index (out_ch.word_index),
  .word_value (out_ch.word_value),
  .last       (out_ch.last)
);

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sfr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_TAIL = 120;
  localparam int PRINT_CAP = 40;

  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_LEN,
    PH_BODY
  } rx_phase_t;

  typedef struct {
    sfr_kind_t          kind;
    logic [7:0]         ftype;
    logic [4:0]         word_idx;
    logic signed [15:0] value;
    logic               last;
  } frame_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = 5'd0;

  sfr_byte_if   in_ch ();
  sfr_result_if out_ch ();

  sensor_frame_receiver_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Parser state as the block should hold it.
  rx_phase_t  rx_phase = PH_HDR1;
  int         rx_len = 0;
  int         rx_pos = 0;
  logic [7:0] rx_sum = 8'd0;
  logic [7:0] frame_copy [BUFFER_BYTES];
  logic [4:0] words_cfg = WORDS_RESET;

  frame_result_t pending_results [$];

  int error_count = 0;
  int results_seen = 0;
  int bytes_sent = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PRINT_CAP)
      $display("%0t: output word %0d: %s is %0h, predicted %0h", $time, results_seen, what,
               got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", {30'd0, out_ch.kind}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.kind !== want.kind)
          report_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
        if (out_ch.frame_type !== want.ftype)
          report_mismatch("frame_type", 32'(out_ch.frame_type), 32'(want.ftype));
        if (out_ch.word_index !== want.word_idx)
          report_mismatch("word_index", 32'(out_ch.word_index), 32'(want.word_idx));
        if (out_ch.word_value !== want.value)
          report_mismatch("word_value", 32'(out_ch.word_value), 32'(want.value));
        if (out_ch.last !== want.last)
          report_mismatch("last", 32'(out_ch.last), 32'(want.last));
      end
      results_seen++;
    end
  end

  function automatic logic [7:0] stored_byte(input int idx);
    return (idx < BUFFER_BYTES) ? frame_copy[idx] : 8'd0;
  endfunction

  task automatic queue_result(input sfr_kind_t kind, input logic [7:0] ftype,
                              input logic [4:0] word_idx, input logic [15:0] value,
                              input logic last);
    frame_result_t r;
    r.kind = kind;
    r.ftype = ftype;
    r.word_idx = word_idx;
    r.value = value;
    r.last = last;
    pending_results.push_back(r);
  endtask

  task automatic keep_byte(input logic [7:0] b);
    if (rx_pos < BUFFER_BYTES) frame_copy[rx_pos] = b;
    rx_sum = rx_sum + b;
    rx_pos++;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int         n;
    logic [7:0] ftype;
    case (rx_phase)
      PH_HDR1: begin
        rx_pos = 0;
        rx_sum = 8'd0;
        if (b == HDR_FIRST) begin
          keep_byte(b);
          rx_phase = PH_HDR2;
        end
      end
      PH_HDR2: begin
        // A failing second byte is dropped, not retried as a first byte.
        if (b == HDR_SECOND) begin
          keep_byte(b);
          rx_phase = PH_LEN;
        end else begin
          rx_phase = PH_HDR1;
        end
      end
      PH_LEN: begin
        rx_len = b;
        if (b < MIN_LENGTH || b > BUFFER_BYTES) begin
          rx_phase = PH_HDR1;
          queue_result(KIND_LEN_ERR, 8'd0, 5'd0, 16'd0, 1'b1);
        end else begin
          keep_byte(b);
          rx_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        if (rx_pos + 1 < rx_len) begin
          keep_byte(b);
        end else begin
          // The checksum byte is stored but not summed.
          if (rx_pos < BUFFER_BYTES) frame_copy[rx_pos] = b;
          rx_pos++;
          rx_phase = PH_HDR1;
          ftype = stored_byte(3);
          if (b != rx_sum) begin
            queue_result(KIND_SUM_ERR, ftype, 5'd0, 16'd0, 1'b1);
          end else begin
            n = (words_cfg == 5'd0) ? 1 : (words_cfg > MAX_WORDS) ? MAX_WORDS : words_cfg;
            for (int i = 0; i < n; i++)
              queue_result(KIND_WORD, ftype, 5'(i),
                           {stored_byte(4 + 2 * i), stored_byte(5 + 2 * i)}, i == n - 1);
          end
        end
      end
      default: rx_phase = PH_HDR1;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    parse_byte(b);
  endtask

  // Sends header, length, type, payload and checksum. An illegal length sends
  // only the first three bytes, since the parser drops back to hunting there.
  task automatic send_frame(input int len, input logic [7:0] ftype, input bit bad_sum,
                            input bit extremes);
    logic [63:0] pattern;
    logic [7:0]  fb [$];
    logic [7:0]  sum;
    pattern = 64'h8000_7FFF_FFFF_0000;
    fb = {HDR_FIRST, HDR_SECOND, 8'(len)};
    if (len >= MIN_LENGTH && len <= BUFFER_BYTES) begin
      for (int k = 3; k < len - 1; k++)
        fb.push_back(k == 3 ? ftype :
                     extremes ? pattern[63 - 8 * ((k - 4) % 8) -: 8] : 8'($urandom));
      sum = 8'd0;
      foreach (fb[k]) sum = sum + fb[k];
      fb.push_back(bad_sum ? sum + 8'($urandom_range(255, 1)) : sum);
    end
    foreach (fb[k]) send_byte(fb[k]);
  endtask

  // Feeds zero bytes until the parser is hunting again.
  task automatic return_to_hunt();
    while (rx_phase != PH_HDR1) send_byte(8'h00);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic set_words(input logic [4:0] value);
    return_to_hunt();
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    words_cfg = value;
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 6) return BUFFER_BYTES;
    if (r < 20) return $urandom_range(BUFFER_BYTES - 1, 17);
    return $urandom_range(16, 4);
  endfunction

  // The first good frame fills the whole store, so no later word reads an
  // entry that was never written.
  task automatic test_default_count();
    send_frame(BUFFER_BYTES, 8'h3C, 1'b0, 1'b0);
  endtask

  // Short frames with many words also read what earlier frames left behind.
  task automatic test_word_limits();
    set_words(MAX_WORDS);
    send_frame(14, 8'hFF, 1'b0, 1'b1);
    set_words(5'd31);
    send_frame(10, 8'h00, 1'b0, 1'b1);
    set_words(5'd0);
    send_frame(6, 8'h5A, 1'b0, 1'b0);
    set_words(5'd1);
    send_frame(5, 8'h81, 1'b0, 1'b0);
  endtask

  // Length four has no type byte; the checksum stands in its place.
  task automatic test_short_frames();
    set_words(5'd3);
    send_frame(4, 8'h00, 1'b0, 1'b0);
    send_frame(5, 8'h7E, 1'b0, 1'b0);
    send_frame(4, 8'h00, 1'b1, 1'b0);
  endtask

  task automatic test_bad_length();
    send_frame(0, 8'h00, 1'b0, 1'b0);
    send_frame(MIN_LENGTH - 1, 8'h00, 1'b0, 1'b0);
    send_frame(BUFFER_BYTES + 1, 8'h00, 1'b0, 1'b0);
    send_frame(255, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_checksum_error();
    send_frame(10, 8'hA5, 1'b1, 1'b0);
    send_frame(14, 8'hC3, 1'b1, 1'b1);
  endtask

  task automatic test_header_mismatch();
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_frame(9, 8'h11, 1'b0, 1'b0);
    send_byte(HDR_FIRST);
    send_byte(8'h00);
    send_byte(HDR_SECOND);
    send_frame(6, 8'hE7, 1'b0, 1'b0);
  endtask

  // The receiver holds off while frames keep coming, so the block has to
  // stall its input.
  task automatic test_output_hold();
    set_words(MAX_WORDS);
    hold_cycles = 400;
    repeat (3) send_frame(10, 8'($urandom), 1'b0, 1'b0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                     input logic [4:0] words, input int nbytes);
    int first;
    int r;
    int cnt;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    set_words(words);
    first = bytes_sent;
    while (bytes_sent - first < nbytes) begin
      r = $urandom_range(99);
      if (r < 62) begin
        send_frame(pick_length(), 8'($urandom), 1'b0, $urandom_range(7) == 0);
      end else if (r < 72) begin
        send_frame(pick_length(), 8'($urandom), 1'b1, 1'b0);
      end else if (r < 80) begin
        send_frame($urandom_range(1) ? $urandom_range(MIN_LENGTH - 1) :
                   $urandom_range(255, BUFFER_BYTES + 1), 8'h00, 1'b0, 1'b0);
      end else if (r < 88) begin
        send_byte(HDR_FIRST);
        cnt = $urandom_range(255);
        send_byte(cnt == HDR_SECOND ? HDR_FIRST : 8'(cnt));
      end else begin
        cnt = $urandom_range(6, 1);
        repeat (cnt) send_byte($urandom_range(3) == 0 ? HDR_FIRST : 8'($urandom));
      end
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    foreach (frame_copy[k]) frame_copy[k] = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_count();
    test_word_limits();
    test_short_frames();
    test_bad_length();
    test_checksum_error();
    test_header_mismatch();
    test_output_hold();
    test_random_traffic(0, 0, 5'($urandom_range(31)), 8);
    test_random_traffic(79, 0, 5'd1, 8);
    test_random_traffic(0, 79, MAX_WORDS, 8);
    test_random_traffic(13, 13, 5'($urandom_range(31)), 8);

    return_to_hunt();
    drain_results();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/sfr_pkg.sv
hdl/sfr_byte_if.sv
hdl/sfr_result_if.sv
hdl/sfr_ram.sv
hdl/sfr_parser.sv
hdl/sfr_emitter.sv
hdl/sensor_frame_receiver_top.sv
hdl/sfr_checker.sv
bench/tb_top.sv
